// ===== sv/sira_pkg.sv =====
// shared constants, types and the digit character function for the radix converter
package sira_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int BITS_PER_CYCLE      = 8;
  localparam int RADIX_W             = 6;
  localparam int REM_W               = RADIX_W + 1;
  localparam int CHAR_W              = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd35;
  localparam logic [CHAR_W-1:0]  MINUS_CODE = 8'h2D;
  localparam logic [CHAR_W-1:0]  BAD_CODE   = 8'h00;
  localparam logic [CHAR_W-1:0]  ZERO_CODE  = 8'h30;
  localparam logic [CHAR_W-1:0]  ALPHA_CODE = 8'h41;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_LOAD,
    ST_BAD
  } state_t;

  // ascii for one digit value, 0..9 then A..Y
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] code;
    if (d < DEC_DIGITS) begin
      code = ZERO_CODE + {2'b00, d};
    end else begin
      code = ALPHA_CODE + {2'b00, d - DEC_DIGITS};
    end
    return code;
  endfunction

endpackage

// ===== sv/sira_ram.sv =====
// generic single-write, single-read ram with registered read data
module sira_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sira_div.sv =====
// iterative restoring divider by a small radix, BITS_PER_CYCLE quotient bits per cycle
module sira_div #(
  parameter int VALUE_WIDTH = sira_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [VALUE_WIDTH-1:0]       dividend,
  input  logic [sira_pkg::RADIX_W-1:0] divisor,
  output logic                         done,
  output logic [VALUE_WIDTH-1:0]       quotient,
  output logic [sira_pkg::RADIX_W-1:0] remainder
);
  import sira_pkg::*;

  localparam int PAD_W  = ((VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE)
                          * BITS_PER_CYCLE;
  localparam int CYCLES = PAD_W / BITS_PER_CYCLE;
  localparam int CNT_W  = $clog2(CYCLES + 1);

  logic [PAD_W-1:0]   work, work_next;
  logic [REM_W-1:0]   rem, rem_next;
  logic [RADIX_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;

  // one group of shift/compare/subtract steps
  always_comb begin
    logic [PAD_W-1:0] w;
    logic [REM_W-1:0] r;
    w = work;
    r = rem;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      r = {r[REM_W-2:0], w[PAD_W-1]};
      w = {w[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        w[0] = 1'b1;
      end
    end
    work_next = w;
    rem_next  = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(CYCLES);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= PAD_W'(dividend);
      rem  <= '0;
      dvs  <= divisor;
    end else if (cnt != '0) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work[VALUE_WIDTH-1:0];
  assign remainder = rem[RADIX_W-1:0];

endmodule

// ===== sv/signed_integer_to_radix_ascii.sv =====
// top level: signed integer to ascii text in radix 2..35
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------
//  input    | in_valid/in_stall  | number, radix
//  output   | out_valid/out_stall| char_code, last, bad_radix
//
// each digit is one division in the shared divider, 8 quotient bits per cycle, and the
// next division starts when one finishes; each digit character then goes through
// the digit ram read (ST_FETCH, ST_LOAD), the minus sign straight from ST_SIGN.
// a bad radix gives a single character with last and bad_radix set.
// synchronous reset returns the sequencer to idle with no pending transfer.
// in_stall is high while a conversion runs; out_stall only holds the sequencer.
module signed_integer_to_radix_ascii #(
  parameter int VALUE_WIDTH = sira_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_WIDTH-1:0] number,
  input  logic [sira_pkg::RADIX_W-1:0] radix,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sira_pkg::CHAR_W-1:0]  char_code,
  output logic                         last,
  output logic                         bad_radix
);
  import sira_pkg::*;

  localparam int AW  = $clog2(VALUE_WIDTH);
  localparam int IDX_W = $clog2(VALUE_WIDTH + 1);

  state_t state, state_next;

  logic                   in_xfer, radix_ok, out_free;
  logic                   negative_flag;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [IDX_W-1:0]       digit_count, rd_idx;

  logic                   div_start, div_done;
  logic [VALUE_WIDTH-1:0] div_dividend, div_quotient;
  logic [RADIX_W-1:0]     div_remainder, digit_radix, div_divisor;
  logic                   div_final;

  logic [RADIX_W-1:0]     digit_rdata;
  logic [AW-1:0]          rd_addr;

  logic                   out_load, out_last_next, out_bad_next;
  logic [CHAR_W-1:0]      out_code_next;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign radix_ok  = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign out_free  = !out_valid || !out_stall;
  assign magnitude = number[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(number))
                                           : VALUE_WIDTH'(number);
  assign div_final = div_done && (div_quotient == '0);
  assign rd_addr   = AW'(rd_idx - 1'b1);

  sira_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  sira_ram #(.WIDTH(RADIX_W), .DEPTH(VALUE_WIDTH)) u_digit_store (
    .clk   (clk),
    .we    (div_done),
    .waddr (digit_count[AW-1:0]),
    .wdata (div_remainder),
    .raddr (rd_addr),
    .rdata (digit_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = radix_ok ? ST_DIV : ST_BAD;
        end
      end
      ST_DIV: begin
        if (div_final) begin
          state_next = negative_flag ? ST_SIGN : ST_FETCH;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = (rd_idx == IDX_W'(1)) ? ST_IDLE : ST_FETCH;
        end
      end
      ST_BAD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_start     = 1'b0;
    div_dividend  = magnitude;
    div_divisor   = digit_radix;
    out_load      = 1'b0;
    out_code_next = BAD_CODE;
    out_last_next = 1'b0;
    out_bad_next  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // first division starts on the accepting edge, before digit_radix is loaded
        div_start   = in_xfer && radix_ok;
        div_divisor = radix;
      end
      ST_DIV: begin
        div_start    = div_done && !div_final;
        div_dividend = div_quotient;
      end
      ST_SIGN: begin
        out_load      = out_free;
        out_code_next = MINUS_CODE;
      end
      ST_LOAD: begin
        out_load      = out_free;
        out_code_next = digit_char(digit_rdata);
        out_last_next = (rd_idx == IDX_W'(1));
      end
      ST_BAD: begin
        out_load      = out_free;
        out_last_next = 1'b1;
        out_bad_next  = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      digit_count   <= '0;
      negative_flag <= 1'b0;
      rd_idx        <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_xfer && radix_ok) begin
        digit_count   <= '0;
        negative_flag <= number[VALUE_WIDTH-1];
      end else if (div_done) begin
        digit_count <= digit_count + 1'b1;
      end
      // read index starts at the digit count once the last digit lands
      if (div_final) begin
        rd_idx <= digit_count + 1'b1;
      end else if (state == ST_LOAD && out_free) begin
        rd_idx <= rd_idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_radix <= RADIX_MIN;
    end else if (in_xfer) begin
      digit_radix <= radix;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_code <= out_code_next;
      last      <= out_last_next;
      bad_radix <= out_bad_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= IDX_W'(VALUE_WIDTH))
    else $error("digit count beyond value width");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last_next) |=> (state == ST_IDLE))
    else $error("last character loaded without returning to idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_load_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (rd_idx != '0) && (rd_idx <= digit_count))
    else $error("digit read index out of range");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> (state == ST_IDLE) && $past(state_next == ST_IDLE))
    else $error("input transfer while a conversion runs");

endmodule
